@@ rtl/lmgps_pkg.sv @@
// Shared types, constants and helpers for the LED matrix gamma PWM scanner.
`timescale 1ns / 1ps

package lmgps_pkg;

    // Matrix geometry
    localparam int NUM_COLS  = 7;
    localparam int NUM_ROWS  = 5;
    localparam int COL_W     = 3;
    localparam int ROW_W     = 3;
    localparam int ROW_CODES = 1 << ROW_W;

    // Field and register widths
    localparam int ACT_W   = 2;
    localparam int LVL_W   = 3;
    localparam int STEP_W  = 8;
    localparam int FRAME_W = 4;
    localparam int RSEL_W  = 5;
    localparam int CDRV_W  = 7;
    localparam int GAMMA_W = 64;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 64'h1C10_0906_0402_0100;
    localparam logic [STEP_W-1:0]  STEPS_RESET = 8'd114;
    localparam logic [FRAME_W-1:0] FADE_RESET  = 4'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE  = 2'd2;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;   // unused code, changes nothing

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [COL_W-1:0] cell_col;
        logic [ROW_W-1:0] cell_row;
        logic [LVL_W-1:0] level;
    } req_t;

    typedef struct packed {
        logic [RSEL_W-1:0] row_select;
        logic [CDRV_W-1:0] column_drive;
        logic              frame_end;
    } rsp_t;

    // Scan position plus what a tick at this position would trigger
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [STEP_W-1:0] step;
        logic              frame_end;
        logic              fade;
    } scan_ctl_t;

    function automatic logic [STEP_W-1:0] gamma_of(
        input logic [GAMMA_W-1:0] tbl,
        input logic [LVL_W-1:0]   lvl
    );
        return tbl[{lvl, 3'b000} +: STEP_W];
    endfunction

endpackage

@@ rtl/lmgps_scan.sv @@
// Step, row and frame counters of the scan.
`timescale 1ns / 1ps

module lmgps_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick,
    input  logic [lmgps_pkg::STEP_W-1:0]   steps_per_row,
    input  logic [lmgps_pkg::FRAME_W-1:0]  fade_divider,
    output lmgps_pkg::scan_ctl_t           ctl
);
    import lmgps_pkg::*;

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;

    logic [STEP_W-1:0]  spr_eff;
    logic [FRAME_W-1:0] fdiv_eff;
    logic [STEP_W-1:0]  step_inc;
    logic [ROW_W-1:0]   row_inc;
    logic [FRAME_W-1:0] frame_inc;
    logic               row_end;
    logic               last_row;
    logic               fade_hit;

    always_comb
    begin
        // zero in either register acts as one
        spr_eff   = (steps_per_row == '0) ? STEP_W'(1) : steps_per_row;
        fdiv_eff  = (fade_divider == '0) ? FRAME_W'(1) : fade_divider;
        step_inc  = step_reg + STEP_W'(1);
        row_inc   = row_reg + ROW_W'(1);
        frame_inc = frame_reg + FRAME_W'(1);
        row_end   = (step_inc >= spr_eff) || (step_inc == '0);
        last_row  = ({1'b0, row_inc} >= (ROW_W + 1)'(NUM_ROWS)) || (row_inc == '0);
        fade_hit  = (frame_inc >= fdiv_eff) || (frame_inc == '0);

        ctl.row       = row_reg;
        ctl.step      = step_reg;
        ctl.frame_end = row_end && last_row;
        ctl.fade      = row_end && last_row && fade_hit;

        step_next  = step_reg;
        row_next   = row_reg;
        frame_next = frame_reg;
        if (tick)
        begin
            step_next = row_end ? '0 : step_inc;
            if (row_end)
            begin
                row_next = last_row ? '0 : row_inc;
                if (last_row)
                begin
                    frame_next = fade_hit ? '0 : frame_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            row_reg   <= '0;
            frame_reg <= '0;
        end
        else
        begin
            step_reg  <= step_next;
            row_reg   <= row_next;
            frame_reg <= frame_next;
        end
    end

endmodule

@@ rtl/lmgps_cells.sv @@
// Per-cell shown/target levels, fading and gamma compare of the scan row.
`timescale 1ns / 1ps

module lmgps_cells (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             set_en,
    input  logic                             clear_en,
    input  logic                             fade_en,
    input  lmgps_pkg::req_t                  req,
    input  lmgps_pkg::scan_ctl_t             ctl,
    input  logic [lmgps_pkg::GAMMA_W-1:0]    gamma_table,
    output logic [lmgps_pkg::NUM_COLS-1:0]   columns
);
    import lmgps_pkg::*;

    logic [LVL_W-1:0] shown_reg  [NUM_ROWS][NUM_COLS];
    logic [LVL_W-1:0] shown_next [NUM_ROWS][NUM_COLS];
    logic [LVL_W-1:0] target_reg  [NUM_ROWS][NUM_COLS];
    logic [LVL_W-1:0] target_next [NUM_ROWS][NUM_COLS];

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                shown_next[r][c]  = shown_reg[r][c];
                target_next[r][c] = target_reg[r][c];
                if (clear_en)
                begin
                    shown_next[r][c]  = '0;
                    target_next[r][c] = '0;
                end
                else if (set_en && req.cell_row == ROW_W'(r) && req.cell_col == COL_W'(c))
                begin
                    // cells outside the matrix never match
                    target_next[r][c] = req.level;
                end
                else if (fade_en)
                begin
                    if (shown_reg[r][c] < target_reg[r][c])
                        shown_next[r][c] = shown_reg[r][c] + LVL_W'(1);
                    else if (shown_reg[r][c] > target_reg[r][c])
                        shown_next[r][c] = shown_reg[r][c] - LVL_W'(1);
                end
            end
        end
    end

    // Compare uses the levels before any fade of this tick
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            columns[c] = ctl.step < gamma_of(gamma_table, shown_reg[ctl.row][c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                for (int c = 0; c < NUM_COLS; c++)
                begin
                    shown_reg[r][c]  <= '0;
                    target_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            shown_reg  <= shown_next;
            target_reg <= target_next;
        end
    end

endmodule

@@ rtl/led_matrix_gamma_pwm_scan.sv @@
// Top level of the row-multiplexed LED matrix driver with gamma PWM and fading.
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid/req_stall/req): one request per accepted edge.
//     action TICK drives one PWM step of the current scan row, SET writes one
//     cell's target level, CLEAR zeroes every shown and target level.
//   rsp channel (rsp_valid/rsp_stall/rsp): exactly one response per request.
//     A tick returns the one-hot row select, the column bits of this step and
//     frame_end; other requests return all zero.
//   cfg port (cfg_we/cfg_index/cfg_data): gamma table, steps per row and
//     fade divider; write only while no request is in flight.
// Timing
//   Request register -> compare/update logic -> response register.
//   rsp_valid rises once the response register takes the request's result;
//   one request per cycle is sustained while rsp_stall is low. The path
//   between the registers is set by the gamma table mux and the 7 step compares
//   of the scanned row. While rsp_stall is high a valid response holds; the
//   request register takes one more request and then raises req_stall.
// Reset
//   rst_n clears all levels, the step/row/frame counters and both valid flags,
//   and loads the register defaults. No clearing pass is needed.

module led_matrix_gamma_pwm_scan (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  lmgps_pkg::req_t                     req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output lmgps_pkg::rsp_t                     rsp,
    input  logic                                cfg_we,
    input  logic [lmgps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lmgps_pkg::CFG_W-1:0]         cfg_data
);
    import lmgps_pkg::*;

    localparam logic [ROW_CODES-1:0] LAST_ROW_HOT = ROW_CODES'(1) << (NUM_ROWS - 1);

    // Configuration registers
    logic [GAMMA_W-1:0] gamma_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic [FRAME_W-1:0] fade_reg;

    // Request and response registers
    logic  in_vld_reg, in_vld_next;
    req_t  in_reg;
    logic  rsp_vld_reg, rsp_vld_next;
    rsp_t  rsp_reg, rsp_next;

    logic  advance;
    logic  accept;
    logic  tick_en;
    logic  set_en;
    logic  clear_en;

    scan_ctl_t               ctl;
    logic [NUM_COLS-1:0]     columns;
    logic [ROW_CODES-1:0]    row_hot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
            steps_reg <= STEPS_RESET;
            fade_reg  <= FADE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAMMA: gamma_reg <= cfg_data;
                CFG_STEPS: steps_reg <= cfg_data[STEP_W-1:0];
                CFG_FADE:  fade_reg  <= cfg_data[FRAME_W-1:0];
                default:   ;
            endcase
        end
    end

    // Handshake: the held request moves on when the response slot frees up
    always_comb
    begin
        advance   = in_vld_reg && (!rsp_vld_reg || !rsp_stall);
        req_stall = in_vld_reg && !advance;
        accept    = req_valid && !req_stall;
        tick_en   = advance && (in_reg.action == ACT_TICK);
        set_en    = advance && (in_reg.action == ACT_SET);
        clear_en  = advance && (in_reg.action == ACT_CLEAR);

        in_vld_next = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        rsp_vld_next = advance ? 1'b1 : (rsp_stall ? rsp_vld_reg : 1'b0);
    end

    lmgps_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick_en),
        .steps_per_row (steps_reg),
        .fade_divider  (fade_reg),
        .ctl           (ctl)
    );

    lmgps_cells u_cells (
        .clk         (clk),
        .rst_n       (rst_n),
        .set_en      (set_en),
        .clear_en    (clear_en),
        .fade_en     (tick_en && ctl.fade),
        .req         (in_reg),
        .ctl         (ctl),
        .gamma_table (gamma_reg),
        .columns     (columns)
    );

    always_comb
    begin
        row_hot  = ROW_CODES'(1) << ctl.row;
        rsp_next = '0;
        if (in_reg.action == ACT_TICK)
        begin
            rsp_next.row_select   = RSEL_W'(row_hot);
            rsp_next.column_drive = CDRV_W'(columns);
            rsp_next.frame_end    = ctl.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= req;
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    // Requests back up only behind a stalled, full response slot
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_vld_reg && rsp_stall && in_vld_reg))
        else $error("request stalled without downstream back-pressure");

    // Frame ends only on the last scan row
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && rsp_reg.frame_end) |->
            (rsp_reg.row_select == RSEL_W'(LAST_ROW_HOT)))
        else $error("frame_end outside the last row");

    // Non-tick responses carry nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && rsp_reg.row_select == '0) |->
            (rsp_reg.column_drive == '0 && !rsp_reg.frame_end))
        else $error("non-tick response with drive bits");

    // Tick responses drive exactly one row
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_vld_reg && rsp_reg.row_select != '0) |-> $onehot(rsp_reg.row_select))
        else $error("row select not one-hot");
`endif

endmodule
